### hdl/bmp_pkg.sv
// bmp_pkg: shared widths, register indexes and types for the block mean pixelate block
// no dependencies

package bmp_pkg;

  // field widths fixed by the register map and the result format
  localparam int SZ_W    = 12;
  localparam int PIX_W   = 8;
  localparam int IDX_W   = 11;
  localparam int SUM_W   = 30;
  localparam int AREA_W  = 2 * SZ_W;
  localparam int NUM_W   = 32;
  localparam int CFG_A_W = 8;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_PLANE_W = 8'd0;
  localparam logic [CFG_A_W-1:0] REG_PLANE_H = 8'd1;
  localparam logic [CFG_A_W-1:0] REG_BLOCK_W = 8'd2;
  localparam logic [CFG_A_W-1:0] REG_BLOCK_H = 8'd3;

  // divider status toward the control logic
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/bmp_if.sv
// bmp_if: valid/ready channel interfaces for pixels, block results and register writes
// depends on bmp_pkg

interface bmp_pix_if import bmp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface bmp_blk_if import bmp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] block_mean;
  logic [IDX_W-1:0] block_col;
  logic [IDX_W-1:0] block_row;
  logic             last_block;

  modport source (output valid, output block_mean, output block_col, output block_row,
                  output last_block, input ready);
  modport sink   (input valid, input block_mean, input block_col, input block_row,
                  input last_block, output ready);
endinterface

interface bmp_cfg_if import bmp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CFG_A_W-1:0] index;
  logic [SZ_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/block_mean_pixelate_top.sv
// block_mean_pixelate_top: mosaic block averaging over a raster pixel stream
// depends on bmp_pkg, bmp_if (channel interfaces) and bmp_div
//
// Pixels arrive in raster order; the plane is cut into block_width by block_height
// blocks, clipped at the right and bottom edges, and each finished block yields its
// rounded mean with its column and row index and a last-of-plane flag. One running
// sum per block column sits in a single-port-write, registered-read memory of
// MAX_WIDTH entries. Per pixel, the accept cycle issues the memory read, the next
// cycle adds and writes back. A block's last pixel passes the prepare, divide and
// output states, where the 8-step restoring divider forms the mean. The result sits
// in an output register, so further pixels are taken while it waits for the consumer.
// A size register write restarts the plane at its first pixel; sizes of zero count as
// one and sizes above MAX_WIDTH or MAX_HEIGHT are held at those bounds. The sum
// memory needs no clearing: each block's first pixel overwrites its column's entry.

module block_mean_pixelate_top import bmp_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic       clk,
  input  logic       rst_n,
  bmp_pix_if.sink    in_pix,
  bmp_blk_if.source  out_blk,
  bmp_cfg_if.sink    cfg_wr
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [SZ_W-1:0] W_CAP = (MAX_WIDTH  >= (1 << SZ_W)) ? {SZ_W{1'b1}}
                                                                 : SZ_W'(MAX_WIDTH);
  localparam logic [SZ_W-1:0] H_CAP = (MAX_HEIGHT >= (1 << SZ_W)) ? {SZ_W{1'b1}}
                                                                 : SZ_W'(MAX_HEIGHT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [SZ_W-1:0]   plane_w_r, plane_h_r, block_w_r, block_h_r;
  logic [SZ_W-1:0]   w_eff, h_eff, bw_eff, bh_eff;
  logic [SZ_W-1:0]   px_r, py_r, xib_r, yib_r, bx_r, by_r;
  logic [PIX_W-1:0]  pix_r;
  logic [SUM_W-1:0]  sums_mem [MAX_WIDTH];
  logic [SUM_W-1:0]  rd_data_r;
  logic [SUM_W-1:0]  sum_new;
  logic [SUM_W-1:0]  sum_r;
  logic [AREA_W-1:0] area_r;
  logic [IDX_W-1:0]  col_r, row_r;
  logic              last_r;
  logic              row_end, col_end, blk_right, blk_bottom, blk_done;
  logic              in_xfer, cfg_xfer, cfg_hit;
  logic [AW-1:0]     mem_idx;
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  div_stat_t         div_stat;
  logic [PIX_W-1:0]  div_quot;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_mean_r;
  logic [IDX_W-1:0]  out_col_r, out_row_r;
  logic              out_last_r;
  logic              out_free;

  // handshakes
  assign in_pix.ready = (state_r == S_IDLE);
  assign cfg_wr.ready = 1'b1;
  assign in_xfer      = in_pix.valid && in_pix.ready;
  assign cfg_xfer     = cfg_wr.valid && cfg_wr.ready;
  assign cfg_hit      = cfg_xfer && (cfg_wr.index == REG_PLANE_W ||
                                     cfg_wr.index == REG_PLANE_H ||
                                     cfg_wr.index == REG_BLOCK_W ||
                                     cfg_wr.index == REG_BLOCK_H);
  assign out_free     = !out_valid_r || out_blk.ready;

  // effective sizes: zero counts as one, clamp to the supported bounds
  always_comb begin
    w_eff  = (plane_w_r == '0) ? SZ_W'(1) : ((plane_w_r > W_CAP) ? W_CAP : plane_w_r);
    h_eff  = (plane_h_r == '0) ? SZ_W'(1) : ((plane_h_r > H_CAP) ? H_CAP : plane_h_r);
    bw_eff = (block_w_r == '0) ? SZ_W'(1) : ((block_w_r > W_CAP) ? W_CAP : block_w_r);
    bh_eff = (block_h_r == '0) ? SZ_W'(1) : ((block_h_r > H_CAP) ? H_CAP : block_h_r);
  end

  // position flags for the pixel in flight
  assign row_end    = px_r >= w_eff - SZ_W'(1);
  assign col_end    = py_r >= h_eff - SZ_W'(1);
  assign blk_right  = row_end || (xib_r >= bw_eff - SZ_W'(1));
  assign blk_bottom = col_end || (yib_r >= bh_eff - SZ_W'(1));
  assign blk_done   = blk_right && blk_bottom;
  assign mem_idx    = AW'(bx_r);

  // first pixel of a block overwrites the column sum
  assign sum_new = (xib_r == '0 && yib_r == '0) ? SUM_W'(pix_r)
                                                : rd_data_r + SUM_W'(pix_r);

  // column sum memory, registered read
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data_r <= sums_mem[mem_idx];
    end
    if (state_r == S_ADD) begin
      sums_mem[mem_idx] <= sum_new;
    end
  end

  // state sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_ADD;
      S_ADD:  state_nxt = blk_done ? S_PREP : S_IDLE;
      S_PREP: state_nxt = S_DIV;
      S_DIV:  if (div_stat.done) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers and position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_w_r <= SZ_W'(2048);
      plane_h_r <= SZ_W'(2048);
      block_w_r <= SZ_W'(8);
      block_h_r <= SZ_W'(8);
      px_r      <= '0;
      py_r      <= '0;
      xib_r     <= '0;
      yib_r     <= '0;
      bx_r      <= '0;
      by_r      <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_wr.index)
        REG_PLANE_W: plane_w_r <= cfg_wr.data;
        REG_PLANE_H: plane_h_r <= cfg_wr.data;
        REG_BLOCK_W: block_w_r <= cfg_wr.data;
        default:     block_h_r <= cfg_wr.data;
      endcase
      px_r  <= '0;
      py_r  <= '0;
      xib_r <= '0;
      yib_r <= '0;
      bx_r  <= '0;
      by_r  <= '0;
    end else if (state_r == S_ADD) begin
      if (row_end) begin
        px_r  <= '0;
        xib_r <= '0;
        bx_r  <= '0;
        if (col_end) begin
          py_r  <= '0;
          yib_r <= '0;
          by_r  <= '0;
        end else begin
          py_r <= py_r + SZ_W'(1);
          if (yib_r >= bh_eff - SZ_W'(1)) begin
            yib_r <= '0;
            by_r  <= by_r + SZ_W'(1);
          end else begin
            yib_r <= yib_r + SZ_W'(1);
          end
        end
      end else begin
        px_r <= px_r + SZ_W'(1);
        if (xib_r >= bw_eff - SZ_W'(1)) begin
          xib_r <= '0;
          bx_r  <= bx_r + SZ_W'(1);
        end else begin
          xib_r <= xib_r + SZ_W'(1);
        end
      end
    end
  end

  // pixel capture and finished-block context
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pix_r <= in_pix.pixel_value;
    end
    if (state_r == S_ADD) begin
      sum_r  <= sum_new;
      area_r <= AREA_W'(xib_r + SZ_W'(1)) * AREA_W'(yib_r + SZ_W'(1));
      col_r  <= bx_r[IDX_W-1:0];
      row_r  <= by_r[IDX_W-1:0];
      last_r <= row_end && col_end;
    end
  end

  // rounded mean: (sum + area/2) / area
  assign div_start = (state_r == S_PREP);
  assign div_num   = NUM_W'(sum_r) + NUM_W'(area_r >> 1);

  bmp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (area_r),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_blk.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_mean_r <= div_quot;
      out_col_r  <= col_r;
      out_row_r  <= row_r;
      out_last_r <= last_r;
    end
  end

  assign out_blk.valid      = out_valid_r;
  assign out_blk.block_mean = out_mean_r;
  assign out_blk.block_col  = out_col_r;
  assign out_blk.block_row  = out_row_r;
  assign out_blk.last_block = out_last_r;

  // checks
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_px_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> px_r < w_eff && py_r < h_eff)
    else $error("pixel position outside the plane");

  a_xib_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> xib_r < bw_eff && yib_r < bh_eff)
    else $error("position within block out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_valid_r && !out_blk.ready |=> state_r == S_OUT)
    else $error("block result left while output register still full");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

endmodule

### hdl/bmp_div.sv
// bmp_div: restoring divider, one quotient bit per cycle, 8-bit quotient
// depends on bmp_pkg; the caller guarantees num < 256 * den

module bmp_div import bmp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [AREA_W-1:0] den,
  output div_stat_t         stat,
  output logic [PIX_W-1:0]  quot
);

  localparam int STEP_W = $clog2(PIX_W);

  logic [NUM_W-1:0]  rem_r;
  logic [AREA_W-1:0] den_r;
  logic [PIX_W-1:0]  q_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [NUM_W-1:0]  shifted;

  // divisor aligned to the current quotient bit
  assign shifted = NUM_W'(den_r) << step_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath: compare and subtract per step
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      q_r    <= '0;
      step_r <= STEP_W'(PIX_W - 1);
    end else if (busy_r) begin
      if (rem_r >= shifted) begin
        rem_r     <= rem_r - shifted;
        q_r[step_r] <= 1'b1;
      end
      step_r <= step_r - STEP_W'(1);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule
